// File: design/nsf_pkg.sv
package nsf_pkg;

    localparam int BYTE_W   = 8;
    localparam int TALKER_W = 16;
    localparam int ID_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IDCNT_W    = 3;

    localparam logic [BYTE_W-1:0] CH_START = 8'h24;
    localparam logic [BYTE_W-1:0] CH_END   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SEP   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_PROP  = 8'h50;

    localparam logic [BYTE_W-1:0] MAX_LENGTH_RST = 8'd82;
    localparam logic [BYTE_W-1:0] POS_MAX        = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ID0 = 3'd2;

    typedef enum logic [2:0] {
        ST_BYPASS  = 3'd0,
        ST_STARTED = 3'd1,
        ST_PROCESS = 3'd2,
        ST_READY   = 3'd3,
        ST_TOOBIG  = 3'd4,
        ST_SKIPPED = 3'd5,
        ST_CHKERR  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        PH_BODY = 2'd0,
        PH_HI   = 2'd1,
        PH_LO   = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic {
        CMD_DATA    = 1'b0,
        CMD_RELEASE = 1'b1
    } t_command;

    function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return v;
    endfunction

endpackage

// File: design/nsf_in_if.sv
interface nsf_in_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [nsf_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, command, data_byte, input ready);
    modport sink   (input valid, command, data_byte, output ready);
endinterface

// File: design/nsf_out_if.sv
interface nsf_out_if;
    logic                         valid;
    logic                         ready;
    nsf_pkg::t_status             status;
    logic                         write_enable;
    logic [nsf_pkg::BYTE_W-1:0]   write_position;
    logic [nsf_pkg::BYTE_W-1:0]   write_byte;
    logic [nsf_pkg::TALKER_W-1:0] talker_id;
    logic [nsf_pkg::ID_W-1:0]     sentence_id;
    logic                         proprietary;
    logic                         checksum_present;

    modport source (output valid, status, write_enable, write_position, write_byte,
                    talker_id, sentence_id, proprietary, checksum_present,
                    input ready);
    modport sink   (input valid, status, write_enable, write_position, write_byte,
                    talker_id, sentence_id, proprietary, checksum_present,
                    output ready);
endinterface

// File: design/nmea_sentence_framer.sv
// Channel   Dir  Payload                                     Handshake
// i_in      in   command, data_byte                          valid/ready
// o_out     out  status, write_enable, write_position,       valid/ready
//                write_byte, talker_id, sentence_id,
//                proprietary, checksum_present
// cfg       in   i_cfg_we, i_cfg_index, i_cfg_data           write only
//
// One transaction per cycle while results are taken; the result appears in the cycle after acceptance.
// Sentence state and the result register update in the accepting cycle.
// i_in.ready is low only while a held result is not being taken.
// Synchronous active-low reset clears state and config to defaults.
module nmea_sentence_framer #(
    parameter int MAX_IDS = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    nsf_in_if.sink                             i_in,
    nsf_out_if.source                          o_out
);

    logic [nsf_pkg::BYTE_W-1:0]   r_max_length;
    logic [nsf_pkg::IDCNT_W-1:0]  r_id_count;
    logic [nsf_pkg::ID_W-1:0]     r_accept_id [MAX_IDS];

    logic                         r_ready_flag,   n_ready_flag;
    logic                         r_started,      n_started;
    logic [nsf_pkg::BYTE_W-1:0]   r_position,     n_position;
    logic [nsf_pkg::BYTE_W-1:0]   r_computed,     n_computed;
    logic [nsf_pkg::BYTE_W-1:0]   r_declared,     n_declared;
    nsf_pkg::t_phase              r_phase,        n_phase;
    logic                         r_prop,         n_prop;
    logic                         r_chk_seen,     n_chk_seen;
    logic [nsf_pkg::TALKER_W-1:0] r_talker,       n_talker;
    logic [nsf_pkg::ID_W-1:0]     r_sentence,     n_sentence;

    logic                         r_out_valid;
    nsf_pkg::t_status             r_status,       n_status;
    logic                         r_we,           n_we;
    logic [nsf_pkg::BYTE_W-1:0]   r_wpos,         n_wpos;
    logic [nsf_pkg::BYTE_W-1:0]   r_wbyte,        n_wbyte;

    logic                         accept;
    logic [nsf_pkg::BYTE_W-1:0]   b;
    logic [nsf_pkg::ID_W-1:0]     id_full;
    logic                         id_hit;
    logic [MAX_IDS-1:0]           id_match;
    logic [nsf_pkg::BYTE_W-1:0]   declared_sum;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    assign id_full      = r_sentence | {{(nsf_pkg::ID_W-nsf_pkg::BYTE_W){1'b0}}, b};
    assign declared_sum = r_declared + {4'd0, nsf_pkg::hex_value(b)};

    for (genvar g = 0; g < MAX_IDS; g++) begin : g_ids
        assign id_match[g] = (nsf_pkg::IDCNT_W'(g) < r_id_count) &&
                             (r_accept_id[g] == id_full);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_accept_id[g] <= '0;
            end else if (i_cfg_we &&
                         i_cfg_index == nsf_pkg::CFG_IDX_W'(nsf_pkg::CFG_ACCEPT_ID0 + g)) begin
                r_accept_id[g] <= i_cfg_data;
            end
        end
    end

    assign id_hit = |id_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= nsf_pkg::MAX_LENGTH_RST;
            r_id_count   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == nsf_pkg::CFG_MAX_LENGTH) begin
                r_max_length <= i_cfg_data[nsf_pkg::BYTE_W-1:0];
            end
            if (i_cfg_index == nsf_pkg::CFG_ID_COUNT) begin
                r_id_count <= i_cfg_data[nsf_pkg::IDCNT_W-1:0];
            end
        end
    end

    always_comb begin
        n_ready_flag = r_ready_flag;
        n_started    = r_started;
        n_position   = r_position;
        n_computed   = r_computed;
        n_declared   = r_declared;
        n_phase      = r_phase;
        n_prop       = r_prop;
        n_chk_seen   = r_chk_seen;
        n_talker     = r_talker;
        n_sentence   = r_sentence;
        n_status     = nsf_pkg::ST_BYPASS;
        n_we         = 1'b0;
        n_wpos       = '0;

        if (i_in.command == nsf_pkg::CMD_RELEASE) begin
            n_ready_flag = 1'b0;
        end else if (!r_ready_flag) begin
            if (b == nsf_pkg::CH_START) begin
                n_started  = 1'b1;
                n_status   = nsf_pkg::ST_STARTED;
                n_computed = '0;
                n_declared = '0;
                n_phase    = nsf_pkg::PH_BODY;
                n_talker   = '0;
                n_sentence = '0;
                n_prop     = 1'b0;
                n_chk_seen = 1'b0;
                n_we       = (r_max_length != '0);
                n_wpos     = '0;
                n_position = 8'd1;
            end else if (r_started) begin
                n_status = nsf_pkg::ST_PROCESS;
                n_we     = (r_position < r_max_length);
                n_wpos   = r_position;
                priority if (b == nsf_pkg::CH_END) begin
                    n_started    = 1'b0;
                    n_ready_flag = 1'b1;
                    n_status     = nsf_pkg::ST_READY;
                end else if (b == nsf_pkg::CH_SEP) begin
                    n_phase    = nsf_pkg::PH_HI;
                    n_chk_seen = 1'b1;
                end else if (r_position >= r_max_length) begin
                    n_started = 1'b0;
                    n_status  = nsf_pkg::ST_TOOBIG;
                end else begin
                    unique case (r_phase)
                        nsf_pkg::PH_BODY: begin
                            n_computed = r_computed ^ b;
                            unique case (r_position)
                                8'd1: begin
                                    if (b == nsf_pkg::CH_PROP) begin
                                        n_prop = 1'b1;
                                    end else begin
                                        n_talker = {b, 8'd0};
                                    end
                                end
                                8'd2: begin
                                    if (r_prop) begin
                                        n_sentence = {b, 24'd0};
                                    end else begin
                                        n_talker = {r_talker[15:8], b};
                                    end
                                end
                                8'd3: begin
                                    if (r_prop) begin
                                        n_sentence = r_sentence | {8'd0, b, 16'd0};
                                    end else begin
                                        n_sentence = {8'd0, b, 16'd0};
                                    end
                                end
                                8'd4: begin
                                    n_sentence = r_sentence | {16'd0, b, 8'd0};
                                end
                                8'd5: begin
                                    n_sentence = id_full;
                                    if (!id_hit) begin
                                        n_started = 1'b0;
                                        n_status  = nsf_pkg::ST_SKIPPED;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        nsf_pkg::PH_HI: begin
                            n_declared = {nsf_pkg::hex_value(b), 4'd0};
                            n_phase    = nsf_pkg::PH_LO;
                        end
                        nsf_pkg::PH_LO: begin
                            n_declared = declared_sum;
                            if (r_computed != declared_sum) begin
                                n_started = 1'b0;
                                n_status  = nsf_pkg::ST_CHKERR;
                            end
                            n_phase = nsf_pkg::PH_DONE;
                        end
                        nsf_pkg::PH_DONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
                if (r_position != nsf_pkg::POS_MAX) begin
                    n_position = r_position + 8'd1;
                end
            end
        end
        n_wbyte = n_we ? b : '0;
        if (!n_we) begin
            n_wpos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_flag <= 1'b0;
            r_started    <= 1'b0;
            r_position   <= '0;
            r_computed   <= '0;
            r_declared   <= '0;
            r_phase      <= nsf_pkg::PH_BODY;
            r_prop       <= 1'b0;
            r_chk_seen   <= 1'b0;
            r_talker     <= '0;
            r_sentence   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_ready_flag <= n_ready_flag;
                r_started    <= n_started;
                r_position   <= n_position;
                r_computed   <= n_computed;
                r_declared   <= n_declared;
                r_phase      <= n_phase;
                r_prop       <= n_prop;
                r_chk_seen   <= n_chk_seen;
                r_talker     <= n_talker;
                r_sentence   <= n_sentence;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload, snapshot of state after the step
    logic [nsf_pkg::TALKER_W-1:0] r_o_talker;
    logic [nsf_pkg::ID_W-1:0]     r_o_sentence;
    logic                         r_o_prop;
    logic                         r_o_chk;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_we         <= n_we;
            r_wpos       <= n_wpos;
            r_wbyte      <= n_wbyte;
            r_o_talker   <= n_talker;
            r_o_sentence <= n_sentence;
            r_o_prop     <= n_prop;
            r_o_chk      <= n_chk_seen;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_status;
    assign o_out.write_enable     = r_we;
    assign o_out.write_position   = r_wpos;
    assign o_out.write_byte       = r_wbyte;
    assign o_out.talker_id        = r_o_talker;
    assign o_out.sentence_id      = r_o_sentence;
    assign o_out.proprietary      = r_o_prop;
    assign o_out.checksum_present = r_o_chk;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import nsf_pkg::*;

    localparam int ID_SLOTS    = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    localparam int CHK_NONE   = 0;
    localparam int CHK_GOOD   = 1;
    localparam int CHK_BAD    = 2;
    localparam int CHK_REPEAT = 3;

    typedef struct packed {
        t_status               status;
        logic                  write_enable;
        logic [BYTE_W-1:0]     write_position;
        logic [BYTE_W-1:0]     write_byte;
        logic [TALKER_W-1:0]   talker_id;
        logic [ID_W-1:0]       sentence_id;
        logic                  proprietary;
        logic                  checksum_present;
    } sentence_out_t;

    class sentence_tracker;
        logic [BYTE_W-1:0]   max_len;
        logic [IDCNT_W-1:0]  id_cnt;
        logic [ID_W-1:0]     accept_ids[ID_SLOTS];
        bit                  holding;
        bit                  in_frame;
        bit                  prop_flag;
        bit                  star_seen;
        logic [BYTE_W-1:0]   pos;
        logic [BYTE_W-1:0]   running_sum;
        logic [BYTE_W-1:0]   declared_sum;
        t_phase              digit_phase;
        logic [TALKER_W-1:0] talker;
        logic [ID_W-1:0]     captured_id;
        sentence_out_t       expected_frames[$];
        int                  mismatches;

        function new();
            max_len = MAX_LENGTH_RST;
            id_cnt = '0;
            foreach (accept_ids[k]) accept_ids[k] = '0;
            holding = 1'b0;
            in_frame = 1'b0;
            prop_flag = 1'b0;
            star_seen = 1'b0;
            pos = '0;
            running_sum = '0;
            declared_sum = '0;
            digit_phase = PH_BODY;
            talker = '0;
            captured_id = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_MAX_LENGTH) begin
                max_len = val[BYTE_W-1:0];
            end else if (idx == CFG_ID_COUNT) begin
                id_cnt = val[IDCNT_W-1:0];
            end else if (idx >= CFG_ACCEPT_ID0) begin
                accept_ids[idx - CFG_ACCEPT_ID0] = val;
            end
        endfunction

        function bit id_known(logic [ID_W-1:0] id);
            int n;
            bit hit;
            hit = 1'b0;
            n = (id_cnt > ID_SLOTS) ? ID_SLOTS : int'(id_cnt);
            for (int k = 0; k < n; k++) begin
                if (accept_ids[k] == id) hit = 1'b1;
            end
            return hit;
        endfunction

        function logic [3:0] nibble(logic [BYTE_W-1:0] c);
            if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
            if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
            if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
            return 4'd0;
        endfunction

        function void frame_byte(t_command cmd, logic [BYTE_W-1:0] b);
            sentence_out_t f;
            f = '0;
            f.status = ST_BYPASS;
            if (cmd == CMD_RELEASE) begin
                holding = 1'b0;
            end else if (!holding) begin
                if (b == CH_START) begin
                    in_frame = 1'b1;
                    f.status = ST_STARTED;
                    running_sum = '0;
                    declared_sum = '0;
                    digit_phase = PH_BODY;
                    talker = '0;
                    captured_id = '0;
                    prop_flag = 1'b0;
                    star_seen = 1'b0;
                    f.write_enable = (max_len != 8'd0);
                    f.write_position = '0;
                    pos = 8'd1;
                end else if (in_frame) begin
                    f.status = ST_PROCESS;
                    f.write_enable = (pos < max_len);
                    f.write_position = pos;
                    if (b == CH_END) begin
                        in_frame = 1'b0;
                        holding = 1'b1;
                        f.status = ST_READY;
                    end else if (b == CH_SEP) begin
                        digit_phase = PH_HI;
                        star_seen = 1'b1;
                    end else if (pos >= max_len) begin
                        in_frame = 1'b0;
                        f.status = ST_TOOBIG;
                    end else begin
                        case (digit_phase)
                            PH_BODY: begin
                                running_sum ^= b;
                                case (pos)
                                    8'd1: begin
                                        if (b == CH_PROP) prop_flag = 1'b1;
                                        else talker = {b, 8'h00};
                                    end
                                    8'd2: begin
                                        if (prop_flag) captured_id = {b, 24'h0};
                                        else talker[7:0] = b;
                                    end
                                    8'd3: begin
                                        if (prop_flag) captured_id[23:16] = b;
                                        else captured_id = {8'h00, b, 16'h0};
                                    end
                                    8'd4: captured_id[15:8] = b;
                                    8'd5: begin
                                        captured_id[7:0] = b;
                                        if (!id_known(captured_id)) begin
                                            in_frame = 1'b0;
                                            f.status = ST_SKIPPED;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                            PH_HI: begin
                                declared_sum = {nibble(b), 4'h0};
                                digit_phase = PH_LO;
                            end
                            PH_LO: begin
                                declared_sum = declared_sum + {4'h0, nibble(b)};
                                if (running_sum != declared_sum) begin
                                    in_frame = 1'b0;
                                    f.status = ST_CHKERR;
                                end
                                digit_phase = PH_DONE;
                            end
                            default: ;
                        endcase
                    end
                    if (pos != POS_MAX) pos++;
                end
            end
            if (f.write_enable) f.write_byte = b;
            else f.write_position = '0;
            f.talker_id = talker;
            f.sentence_id = captured_id;
            f.proprietary = prop_flag;
            f.checksum_present = star_seen;
            expected_frames.push_back(f);
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] got);
            if (got !== exp) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
                mismatches++;
            end
        endfunction

        function void check_frame(sentence_out_t got);
            sentence_out_t exp;
            if (expected_frames.size() == 0) begin
                $error("result with no pending transaction: status %0d", got.status);
                mismatches++;
                return;
            end
            exp = expected_frames.pop_front();
            compare_field("status", exp.status, got.status);
            compare_field("write_enable", exp.write_enable, got.write_enable);
            compare_field("write_position", exp.write_position, got.write_position);
            compare_field("write_byte", exp.write_byte, got.write_byte);
            compare_field("talker_id", exp.talker_id, got.talker_id);
            compare_field("sentence_id", exp.sentence_id, got.sentence_id);
            compare_field("proprietary", exp.proprietary, got.proprietary);
            compare_field("checksum_present", exp.checksum_present, got.checksum_present);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    nsf_in_if  in_bus ();
    nsf_out_if out_bus ();

    nmea_sentence_framer #(
        .MAX_IDS (ID_SLOTS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sentence_tracker tracker;
    logic [ID_W-1:0] id_list[ID_SLOTS];
    bit              hold_request;
    bit              sender_steady;
    int              items_sent;

    function automatic int idle_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [ID_W-1:0] random_id(bit prop);
        logic [ID_W-1:0] v;
        v = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
             8'($urandom_range(65, 90)), 8'($urandom_range(48, 90))};
        if (!prop) v[31:24] = 8'h00;
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        if ($urandom_range(0, 1) == 0) return 8'h41 + {4'h0, n} - 8'd10;
        return 8'h61 + {4'h0, n} - 8'd10;
    endfunction

    task automatic push_item(input t_command cmd, input logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        if (!sender_steady && $urandom_range(0, 3) == 0) gap = idle_length();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.command <= cmd;
        in_bus.data_byte <= b;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        tracker.frame_byte(cmd, b);
        items_sent++;
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        while (tracker.expected_frames.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        tracker.set_register(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [BYTE_W-1:0] ml, input logic [IDCNT_W-1:0] cnt,
                                  input bit fresh_ids);
        drain();
        if (fresh_ids) begin
            for (int k = 0; k < ID_SLOTS; k++) id_list[k] = random_id(k[0]);
        end
        write_register(CFG_MAX_LENGTH, {24'h0, ml});
        write_register(CFG_ID_COUNT, {29'h0, cnt});
        for (int k = 0; k < ID_SLOTS; k++) begin
            write_register(CFG_ACCEPT_ID0 + 3'(k), id_list[k]);
        end
    endtask

    task automatic send_sentence(input logic [ID_W-1:0] id, input bit prop, input int body_len,
                                 input int check_mode, input bit end_line);
        logic [BYTE_W-1:0] line[$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int                extra;
        line.push_back(CH_START);
        if (prop) begin
            line.push_back(CH_PROP);
            line.push_back(id[31:24]);
        end else begin
            line.push_back(8'($urandom_range(65, 79)));
            line.push_back(8'($urandom_range(65, 90)));
        end
        line.push_back(id[23:16]);
        line.push_back(id[15:8]);
        line.push_back(id[7:0]);
        for (int k = 0; k < body_len; k++) begin
            do b = 8'($urandom_range(32, 126)); while (b == CH_START || b == CH_SEP);
            line.push_back(b);
        end
        sum = '0;
        for (int k = 1; k < line.size(); k++) sum ^= line[k];
        case (check_mode)
            CHK_GOOD: begin
                line.push_back(CH_SEP);
                line.push_back(hex_char(sum[7:4]));
                line.push_back(hex_char(sum[3:0]));
            end
            CHK_BAD: begin
                sum ^= 8'h01 << $urandom_range(0, 7);
                line.push_back(CH_SEP);
                if ($urandom_range(0, 3) == 0) line.push_back(8'($urandom_range(71, 90)));
                else line.push_back(hex_char(sum[7:4]));
                line.push_back(hex_char(sum[3:0]));
            end
            CHK_REPEAT: begin
                line.push_back(CH_SEP);
                line.push_back(8'($urandom_range(48, 122)));
                line.push_back(CH_SEP);
                line.push_back(hex_char(sum[7:4]));
                line.push_back(hex_char(sum[3:0]));
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            extra = $urandom_range(1, 3);
            repeat (extra) line.push_back(8'($urandom_range(37, 126)));
        end
        if (end_line) line.push_back(CH_END);
        sender_steady = ($urandom_range(0, 4) == 0);
        foreach (line[k]) push_item(CMD_DATA, line[k]);
    endtask

    task automatic random_sentence();
        logic [ID_W-1:0] id;
        bit              prop;
        int              len;
        int              r;
        int              mode;
        if ($urandom_range(0, 5) == 0) begin
            prop = $urandom_range(0, 1);
            id = random_id(prop);
        end else begin
            id = id_list[$urandom_range(0, ID_SLOTS - 1)];
            prop = (id[31:24] != 8'h00);
        end
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 90) : $urandom_range(0, 12);
        r = $urandom_range(0, 9);
        mode = (r == 0) ? CHK_NONE : (r == 1) ? CHK_BAD : (r == 2) ? CHK_REPEAT : CHK_GOOD;
        send_sentence(id, prop, len, mode, $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 4) == 0) push_item(CMD_DATA, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0) push_item(CMD_RELEASE, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input int budget);
        int stop_at;
        int n;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                sender_steady = 1'b0;
                repeat (n) push_item(t_command'(1'($urandom_range(0, 1))),
                                     8'($urandom_range(0, 255)));
            end
            random_sentence();
        end
    endtask

    initial begin : stimulus
        tracker = new();
        hold_request = 1'b0;
        sender_steady = 1'b0;
        items_sent = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        in_bus.valid <= 1'b0;
        in_bus.command <= CMD_DATA;
        in_bus.data_byte <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: no IDs in use, so this one is dropped at its ID
        send_sentence({8'h00, "GGA"}, 1'b0, 0, CHK_GOOD, 1'b1);
        push_item(CMD_DATA, 8'hFF);
        push_item(CMD_RELEASE, 8'h00);
        push_item(CMD_DATA, 8'h00);

        id_list[0] = {8'h00, "GGA"};
        id_list[1] = "GRME";
        id_list[2] = '1;
        id_list[3] = '0;
        id_list[4] = random_id(1'b0);
        id_list[5] = random_id(1'b1);
        apply_settings(8'd82, 3'd6, 1'b0);
        send_sentence(id_list[1], 1'b1, 0, CHK_GOOD, 1'b1);
        push_item(CMD_DATA, 8'hA5);
        push_item(CMD_RELEASE, 8'hFF);

        apply_settings(8'd82, 3'd6, 1'b1);
        run_phase(60);
        hold_request = 1'b1;
        run_phase(120);

        apply_settings(8'd1, 3'd6, 1'b1);
        run_phase(120);

        // longest sentences: the first one's line feed can land on the saturated position
        apply_settings(8'd255, 3'd7, 1'b1);
        send_sentence(id_list[0], id_list[0][31:24] != 8'h00, 249, CHK_NONE, 1'b1);
        push_item(CMD_RELEASE, 8'h00);
        send_sentence(id_list[3], id_list[3][31:24] != 8'h00, 248, CHK_REPEAT, 1'b1);
        push_item(CMD_RELEASE, 8'h00);
        run_phase(100);

        apply_settings(8'd12, 3'd0, 1'b1);
        run_phase(80);

        apply_settings(8'($urandom_range(1, 255)), 3'($urandom_range(0, 7)), 1'b1);
        run_phase(150);

        apply_settings(8'd82, 3'd2, 1'b1);
        run_phase(150);

        drain();
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : result_sink
        int            stall_left;
        int            mode_left;
        bit            steady;
        sentence_out_t got;
        stall_left = 0;
        mode_left = 0;
        steady = 1'b0;
        out_bus.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
                got.status = out_bus.status;
                got.write_enable = out_bus.write_enable;
                got.write_position = out_bus.write_position;
                got.write_byte = out_bus.write_byte;
                got.talker_id = out_bus.talker_id;
                got.sentence_id = out_bus.sentence_id;
                got.proprietary = out_bus.proprietary;
                got.checksum_present = out_bus.checksum_present;
                tracker.check_frame(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(40, 200);
            end else begin
                mode_left--;
            end
            if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
                stall_left = idle_length();
            end
            out_bus.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
            @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
